[sv/hcbd_pkg.sv]
`timescale 1ns / 1ps

package hcbd_pkg;

    typedef enum logic [6:0] {
        PH_DIGITS  = 7'b0000001,
        PH_EXT     = 7'b0000010,
        PH_LINE_CR = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_TAIL_CR = 7'b0010000,
        PH_TAIL_LF = 7'b0100000,
        PH_FAILED  = 7'b1000000
    } phase_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] payload;
    } res_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h61 + 8'd10);
        end else if (c inside {[8'h41:8'h46]}) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h41 + 8'd10);
        end
        return h;
    endfunction

endpackage

[sv/hcbd_step.sv]
`timescale 1ns / 1ps

module hcbd_step #(
    parameter int SIZE_BITS = 32
) (
    input  hcbd_pkg::phase_t       phase_i,
    input  logic [SIZE_BITS-1:0]   count_i,
    input  logic                   final_i,
    input  logic [7:0]             byte_i,
    output hcbd_pkg::phase_t       phase_o,
    output logic [SIZE_BITS-1:0]   count_o,
    output logic                   final_o,
    output hcbd_pkg::res_t         res_o
);

    hcbd_pkg::hex_t       hex;
    logic                 count_top;
    logic                 count_last;
    logic [SIZE_BITS-1:0] count_one;

    assign count_one  = {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign hex        = hcbd_pkg::hex_decode(byte_i);
    assign count_top  = (count_i[SIZE_BITS-1 -: 4] != 4'd0);
    assign count_last = (count_i == count_one);

    always_comb begin
        phase_o = phase_i;
        count_o = count_i;
        final_o = final_i;
        res_o   = '0;
        case (phase_i)
            hcbd_pkg::PH_DIGITS: begin
                if (hex.ok) begin
                    if (count_top) begin
                        phase_o    = hcbd_pkg::PH_FAILED;
                        res_o.valid = 1'b1;
                        res_o.kind  = hcbd_pkg::KIND_ERROR;
                    end else begin
                        count_o = {count_i[SIZE_BITS-5:0], hex.val};
                    end
                end else if (byte_i == hcbd_pkg::CHAR_CR) begin
                    phase_o = hcbd_pkg::PH_LINE_CR;
                end else begin
                    phase_o = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (byte_i == hcbd_pkg::CHAR_CR) begin
                    phase_o = hcbd_pkg::PH_LINE_CR;
                end
            end
            hcbd_pkg::PH_LINE_CR: begin
                if (byte_i == hcbd_pkg::CHAR_LF) begin
                    if (count_i == '0) begin
                        final_o = 1'b1;
                        phase_o = hcbd_pkg::PH_TAIL_CR;
                    end else begin
                        phase_o = hcbd_pkg::PH_DATA;
                    end
                end else if (byte_i != hcbd_pkg::CHAR_CR) begin
                    phase_o = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_DATA: begin
                count_o       = count_i - count_one;
                res_o.valid   = 1'b1;
                res_o.kind    = hcbd_pkg::KIND_DATA;
                res_o.payload = byte_i;
                if (count_last) begin
                    phase_o = hcbd_pkg::PH_TAIL_CR;
                end
            end
            hcbd_pkg::PH_TAIL_CR: begin
                if (byte_i != hcbd_pkg::CHAR_CR) begin
                    phase_o     = hcbd_pkg::PH_FAILED;
                    res_o.valid = 1'b1;
                    res_o.kind  = hcbd_pkg::KIND_ERROR;
                end else begin
                    phase_o = hcbd_pkg::PH_TAIL_LF;
                end
            end
            hcbd_pkg::PH_TAIL_LF: begin
                if (byte_i != hcbd_pkg::CHAR_LF) begin
                    phase_o     = hcbd_pkg::PH_FAILED;
                    res_o.valid = 1'b1;
                    res_o.kind  = hcbd_pkg::KIND_ERROR;
                end else begin
                    phase_o = hcbd_pkg::PH_DIGITS;
                    count_o = '0;
                    if (final_i) begin
                        final_o     = 1'b0;
                        res_o.valid = 1'b1;
                        res_o.kind  = hcbd_pkg::KIND_END;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/http_chunked_body_decoder_top.sv]
`timescale 1ns / 1ps

// channel  dir  ports                              handshake
// input    in   s_stream_byte                      s_valid / s_ready
// result   out  m_kind, m_payload                  m_valid / m_ready
//
// one byte per cycle; each byte is decoded by the byte fsm and size counter
// in the same cycle it is accepted, its result lands in the output register
// s_ready stays high while the output register is empty or being taken
// a stall on the result side holds one result and blocks input only then
// aresetn is synchronous, active low; the decoder restarts at the size digits

module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_payload
);

    hcbd_pkg::phase_t     phase_reg;
    hcbd_pkg::phase_t     phase_next;
    logic [SIZE_BITS-1:0] count_reg;
    logic [SIZE_BITS-1:0] count_next;
    logic                 final_reg;
    logic                 final_next;
    logic                 m_valid_reg;
    logic [1:0]           m_kind_reg;
    logic [7:0]           m_payload_reg;
    hcbd_pkg::res_t       res;
    logic                 s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    hcbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .phase_i(phase_reg),
        .count_i(count_reg),
        .final_i(final_reg),
        .byte_i (s_stream_byte),
        .phase_o(phase_next),
        .count_o(count_next),
        .final_o(final_next),
        .res_o  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hcbd_pkg::PH_DIGITS;
            count_reg   <= '0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                final_reg   <= final_next;
                m_valid_reg <= res.valid;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res.valid) begin
            m_kind_reg    <= res.kind;
            m_payload_reg <= res.payload;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_payload = m_payload_reg;

    a_failed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == hcbd_pkg::PH_FAILED) |-> !res.valid)
        else $error("result produced in failed phase");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == hcbd_pkg::KIND_ERROR) |-> phase_reg == hcbd_pkg::PH_FAILED)
        else $error("error reported without failed phase");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hcbd_pkg::PH_DATA) |-> count_reg != '0)
        else $error("payload phase with zero count");

endmodule

[test/http_chunked_body_decoder_top_tb.sv]
`timescale 1ns / 1ps

module http_chunked_body_decoder_top_tb;

    localparam int CHUNK_SIZE_BITS = 32;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
    } decoded_t;

    class chunk_decode_sb;
        hcbd_pkg::phase_t           phase;
        logic [CHUNK_SIZE_BITS-1:0] remaining;
        bit                         last_chunk;
        decoded_t                   decoded_q[$];
        int                         mismatches;
        int                         n_data;
        int                         n_end;
        int                         n_error;

        function new();
            phase      = hcbd_pkg::PH_DIGITS;
            remaining  = '0;
            last_chunk = 1'b0;
            mismatches = 0;
            n_data     = 0;
            n_end      = 0;
            n_error    = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void post_result(logic [1:0] k, logic [7:0] p);
            decoded_t w;
            w.kind    = k;
            w.payload = p;
            decoded_q = {decoded_q, w};
        endfunction

        function void fail_format();
            phase = hcbd_pkg::PH_FAILED;
            post_result(hcbd_pkg::KIND_ERROR, 8'h00);
        endfunction

        // called for every accepted input item
        function void take_byte(logic [7:0] c);
            int d;
            d = hex_digit(c);
            case (phase)
                hcbd_pkg::PH_DIGITS: begin
                    if (d >= 0) begin
                        if (remaining[CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
                            fail_format();
                        end else begin
                            remaining = {remaining[CHUNK_SIZE_BITS-5:0], d[3:0]};
                        end
                    end else if (c == hcbd_pkg::CHAR_CR) begin
                        phase = hcbd_pkg::PH_LINE_CR;
                    end else begin
                        phase = hcbd_pkg::PH_EXT;
                    end
                end
                hcbd_pkg::PH_EXT: begin
                    if (c == hcbd_pkg::CHAR_CR) phase = hcbd_pkg::PH_LINE_CR;
                end
                hcbd_pkg::PH_LINE_CR: begin
                    if (c == hcbd_pkg::CHAR_LF) begin
                        if (remaining == '0) begin
                            last_chunk = 1'b1;
                            phase      = hcbd_pkg::PH_TAIL_CR;
                        end else begin
                            phase = hcbd_pkg::PH_DATA;
                        end
                    end else if (c != hcbd_pkg::CHAR_CR) begin
                        phase = hcbd_pkg::PH_EXT;
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    remaining = remaining - 1'b1;
                    if (remaining == '0) phase = hcbd_pkg::PH_TAIL_CR;
                    post_result(hcbd_pkg::KIND_DATA, c);
                end
                hcbd_pkg::PH_TAIL_CR: begin
                    if (c != hcbd_pkg::CHAR_CR) begin
                        fail_format();
                    end else begin
                        phase = hcbd_pkg::PH_TAIL_LF;
                    end
                end
                hcbd_pkg::PH_TAIL_LF: begin
                    if (c != hcbd_pkg::CHAR_LF) begin
                        fail_format();
                    end else begin
                        phase     = hcbd_pkg::PH_DIGITS;
                        remaining = '0;
                        if (last_chunk) begin
                            last_chunk = 1'b0;
                            post_result(hcbd_pkg::KIND_END, 8'h00);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, decoded_t w, logic [1:0] k, logic [7:0] p);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d payload %02h, got kind %0d payload %02h",
                         what, w.kind, w.payload, k, p);
            end
        endfunction

        // called for every accepted result item
        function void check_output(logic [1:0] k, logic [7:0] p);
            decoded_t w;
            if (decoded_q.size() == 0) begin
                w = '1;
                report("unexpected item", w, k, p);
                return;
            end
            w = decoded_q.pop_front();
            if (w.kind != k || w.payload != p) begin
                report("mismatch", w, k, p);
            end else begin
                case (k)
                    hcbd_pkg::KIND_DATA: n_data++;
                    hcbd_pkg::KIND_END:  n_end++;
                    default:             n_error++;
                endcase
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_stream_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_payload;

    chunk_decode_sb sb;
    bit             idle_on = 1'b1;
    int             n_sent = 0;
    int             quiet = 0;
    string          error_case = "none";

    http_chunked_body_decoder_top #(
        .SIZE_BITS(CHUNK_SIZE_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_stream_byte(s_stream_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_payload    (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.take_byte(s_stream_byte);
            if (m_valid && m_ready) sb.check_output(m_kind, m_payload);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet++;
        end else begin
            quiet = 0;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("** http_chunked_body_decoder_top: FAILED **");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic push_crlf();
        push_byte(hcbd_pkg::CHAR_CR);
        push_byte(hcbd_pkg::CHAR_LF);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] nibble_char(int n, bit upper);
        if (n < 10) return 8'("0" + n);
        return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    function automatic logic [7:0] pick_not(logic [7:0] x, logic [7:0] y);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == x || c == y);
        return c;
    endfunction

    // extension text, may carry a lone cr
    task automatic push_extension();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (sb.hex_digit(c) >= 0 || c == hcbd_pkg::CHAR_CR);
        push_byte(c);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) begin
                push_byte(hcbd_pkg::CHAR_CR);
                push_byte(pick_not(hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF));
            end else begin
                push_byte(pick_not(hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_CR));
            end
        end
    endtask

    task automatic push_size_line(input int unsigned size, input int lz, input bit ext);
        int          nd;
        int unsigned t;
        nd = 0;
        t  = size;
        while (t != 0) begin
            nd++;
            t >>= 4;
        end
        repeat (lz) push_byte("0");
        for (int i = nd - 1; i >= 0; i--) begin
            push_byte(nibble_char((size >> (4 * i)) & 4'hf, $urandom_range(0, 1)));
        end
        if (ext) push_extension();
        if ($urandom_range(0, 9) == 0) push_byte(hcbd_pkg::CHAR_CR);
        push_crlf();
    endtask

    task automatic push_body();
        int unsigned size;
        repeat ($urandom_range(0, 4)) begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16);
            push_size_line(size, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0,
                           $urandom_range(0, 3) == 0);
            repeat (size) push_byte(8'($urandom_range(0, 255)));
            push_crlf();
        end
        // last chunk, either one to three "0" digits or an empty size field
        push_size_line(0, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3),
                       $urandom_range(0, 3) == 0);
        push_crlf();
    endtask

    initial begin
        sb = new();
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_stream_byte <= 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // one byte chunk with extension
        push_byte("1");
        push_byte(";");
        push_byte("x");
        push_crlf();
        push_byte(8'hff);
        push_crlf();
        // leading zero, lone cr before the line end
        push_byte("0");
        push_byte("2");
        push_byte(hcbd_pkg::CHAR_CR);
        push_crlf();
        push_byte(8'h00);
        push_byte(8'h80);
        push_crlf();
        // empty size field ends the body
        push_crlf();
        push_crlf();
        push_byte("0");
        push_crlf();
        push_crlf();
        drain_results();

        while (n_sent < 580) begin
            if (n_sent >= 330 && n_sent < 400) drain_results();
            if (n_sent >= 470) idle_on = 1'b0;
            push_body();
        end

        // the block fails for good after this
        case ($urandom_range(0, 2))
            0: begin
                error_case = "size overflow";
                repeat (10) push_byte("0");
                push_byte(nibble_char($urandom_range(1, 15), $urandom_range(0, 1)));
                repeat (8) push_byte(nibble_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
            1: begin
                error_case = "missing cr after chunk";
                push_byte("2");
                push_crlf();
                push_byte(8'($urandom_range(0, 255)));
                push_byte(8'($urandom_range(0, 255)));
                push_byte(pick_not(hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_CR));
            end
            default: begin
                error_case = "missing lf after chunk";
                push_byte("1");
                push_crlf();
                push_byte(8'($urandom_range(0, 255)));
                push_byte(hcbd_pkg::CHAR_CR);
                push_byte(pick_not(hcbd_pkg::CHAR_LF, hcbd_pkg::CHAR_LF));
            end
        endcase
        repeat (12) push_byte(8'($urandom_range(0, 255)));
        push_byte("0");
        push_crlf();
        push_crlf();

        drain_results();
        repeat (20) @(posedge aclk);

        $display("run covered %0d input bytes: %0d payload bytes, %0d bodies ended,",
                 n_sent, sb.n_data, sb.n_end);
        $display("%0d format errors (%s), %0d mismatches", sb.n_error, error_case,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** http_chunked_body_decoder_top: PASSED **");
        end else begin
            $display("** http_chunked_body_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
sv/hcbd_pkg.sv
sv/hcbd_step.sv
sv/http_chunked_body_decoder_top.sv
test/http_chunked_body_decoder_top_tb.sv
